// ===== hdl/jsfd_pkg.sv =====
`default_nettype none

package jsfd_pkg;

   // Default payload buffer size and the sync value loaded at reset.
   localparam int unsigned BUFFER_BYTES_DEFAULT = 16;
   localparam logic [7:0] SYNC_RESET = 8'h2b;

   // Only the first seven payload bytes feed a report.
   localparam int unsigned REPORT_BYTES = 7;

   typedef logic [7:0] byte_type;
   typedef logic [REPORT_BYTES-1:0][7:0] payload_type;
   typedef logic [1:0] packet_id_type;

   // Packet id codes.
   localparam packet_id_type ID_NONE     = 2'd0;
   localparam packet_id_type ID_JOYSTICK = 2'd1;
   localparam packet_id_type ID_SILENT   = 2'd2;
   localparam packet_id_type ID_WHEEL    = 2'd3;
   localparam byte_type      ID_MAX      = 8'd3;

   // One decoded report.
   typedef struct packed {
      logic               report_kind;
      logic signed [15:0] main_axis;
      logic signed [15:0] stick_y;
      logic [7:0]         pedal_one;
      logic [7:0]         pedal_two;
      logic signed [1:0]  hat_x;
      logic signed [1:0]  hat_y;
      logic [11:0]        buttons;
   } report_type;

   // Hat horizontal direction; codes run clockwise from up, eight and above are centered.
   function automatic logic signed [1:0] hat_dx(input logic [3:0] code);
      logic signed [1:0] dx;
      case (code)
         4'd1, 4'd2, 4'd3: dx = 2'sd1;
         4'd5, 4'd6, 4'd7: dx = -2'sd1;
         default:          dx = 2'sd0;
      endcase
      return dx;
   endfunction

   // Hat vertical direction; up is negative.
   function automatic logic signed [1:0] hat_dy(input logic [3:0] code);
      logic signed [1:0] dy;
      case (code)
         4'd0, 4'd1, 4'd7: dy = -2'sd1;
         4'd3, 4'd4, 4'd5: dy = 2'sd1;
         default:          dy = 2'sd0;
      endcase
      return dy;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/jsfd_report_unpack.sv =====
`default_nettype none

module jsfd_report_unpack (
   input  wire jsfd_pkg::payload_type   payload,
   input  wire jsfd_pkg::packet_id_type packet_id,
   output jsfd_pkg::report_type         report
);
   import jsfd_pkg::*;

   logic is_wheel;

   assign is_wheel = (packet_id == ID_WHEEL);

   // Field unpack; pedals are stored inverted, so 255 minus a byte is its complement.
   always_comb begin
      report.report_kind = is_wheel;
      report.main_axis   = {payload[1], payload[0]};
      if (is_wheel) begin
         report.stick_y   = 16'sd0;
         report.pedal_one = ~payload[2];
         report.pedal_two = ~payload[3];
      end else begin
         report.stick_y   = {payload[3], payload[2]};
         report.pedal_one = ~payload[4];
         report.pedal_two = 8'd0;
      end
      report.hat_x   = hat_dx(payload[6][7:4]);
      report.hat_y   = hat_dy(payload[6][7:4]);
      report.buttons = {payload[6][3:0], payload[5]};
   end

endmodule

`default_nettype wire

// ===== hdl/joystick_serial_frame_decoder.sv =====
`default_nettype none
// The closing request is registered in the byte register, then the frame logic sets
// rsp_tvalid and loads the report; a full, untaken report register stalls that step.
// Throughput: one byte per cycle while the report register is free; a byte is registered,
// then one pass of frame logic updates the frame state; the report register, loaded on a
// closing byte, frees on the same cycle it is taken. Reset (synchronous): frame state idle,
// payload bytes zero, sync byte back to 0x2b, both channels empty.

module joystick_serial_frame_decoder #(
   parameter int unsigned BUFFER_BYTES = jsfd_pkg::BUFFER_BYTES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Byte requests in.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   // Reports out.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // [15:0] main_axis, [31:16] stick_y,
                                         // [39:32] pedal_one, [47:40] pedal_two,
                                         // [49:48] hat_x, [51:50] hat_y, [63:52] buttons
   output logic             rsp_tuser,   // [0] report_kind
   // Sync byte register.
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);
   import jsfd_pkg::*;

   localparam int unsigned LEN_W = $clog2(BUFFER_BYTES + 1);
   localparam logic [7:0] BUF_LIMIT = 8'(BUFFER_BYTES);

   logic [7:0]        sync_ff;
   logic              rx_valid_ff;
   logic [7:0]        rx_byte_ff;
   logic              in_packet_ff, in_packet_in;
   packet_id_type     packet_id_ff, packet_id_in;
   logic [LEN_W-1:0]  length_ff, length_in;
   logic [LEN_W-1:0]  index_ff, index_in;
   payload_type       payload_ff, payload_in;
   logic              rsp_valid_ff, rsp_valid_in;
   report_type        report_ff;
   report_type        report;
   logic              out_free;
   logic              process;
   logic              emit;

   // Handshake: the output register frees when empty or taken.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !rx_valid_ff || out_free;
   assign process    = rx_valid_ff && out_free;

   // Report fields come from the stored payload at the closing byte.
   jsfd_report_unpack u_unpack (
      .payload   (payload_ff),
      .packet_id (packet_id_ff),
      .report    (report)
   );

   // Frame sequencing for the registered byte.
   always_comb begin
      in_packet_in = in_packet_ff;
      packet_id_in = packet_id_ff;
      length_in    = length_ff;
      index_in     = index_ff;
      payload_in   = payload_ff;
      emit         = 1'b0;
      if (process) begin
         if (!in_packet_ff) begin
            if (rx_byte_ff == sync_ff) begin
               in_packet_in = 1'b1;
            end
         end else if (packet_id_ff == ID_NONE) begin
            if (rx_byte_ff > ID_MAX) begin
               in_packet_in = 1'b0;
            end else begin
               packet_id_in = rx_byte_ff[1:0];
            end
         end else if (length_ff == '0) begin
            if (rx_byte_ff > BUF_LIMIT) begin
               in_packet_in = 1'b0;
               packet_id_in = ID_NONE;
            end else begin
               length_in = rx_byte_ff[LEN_W-1:0];
            end
         end else if (index_ff < length_ff) begin
            // Bytes past the report fields are counted but never read.
            for (int i = 0; i < REPORT_BYTES; i++) begin
               if (index_ff == LEN_W'(i)) begin
                  payload_in[i] = rx_byte_ff;
               end
            end
            index_in = index_ff + LEN_W'(1);
         end else begin
            // Closing byte: report for joystick and wheel ids only.
            emit         = (packet_id_ff == ID_JOYSTICK) || (packet_id_ff == ID_WHEEL);
            in_packet_in = 1'b0;
            packet_id_in = ID_NONE;
            length_in    = '0;
            index_in     = '0;
         end
      end
   end

   // Output valid register loads on every free cycle.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = emit;
      end
   end

   // Control state, payload bytes and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff      <= SYNC_RESET;
         rx_valid_ff  <= 1'b0;
         in_packet_ff <= 1'b0;
         packet_id_ff <= ID_NONE;
         length_ff    <= '0;
         index_ff     <= '0;
         payload_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            sync_ff <= csr_wr_data;
         end
         if (req_tready) begin
            rx_valid_ff <= req_tvalid;
         end
         in_packet_ff <= in_packet_in;
         packet_id_ff <= packet_id_in;
         length_ff    <= length_in;
         index_ff     <= index_in;
         payload_ff   <= payload_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Data registers need no reset.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         rx_byte_ff <= req_tdata;
      end
      if (emit) begin
         report_ff <= report;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = report_ff.report_kind;
   assign rsp_tdata  = {report_ff.buttons, report_ff.hat_y, report_ff.hat_x,
                        report_ff.pedal_two, report_ff.pedal_one,
                        report_ff.stick_y, report_ff.main_axis};

endmodule

`default_nettype wire
